[design/ucfp_pkg.sv]
`default_nettype none
package ucfp_pkg;

  localparam int MAX_FRAME_LEN = 20;
  localparam int MIN_FRAME_LEN = 4;
  localparam int HEADER_LEN    = 4;
  localparam int TIMEOUT_RESET = 32;

  localparam int BYTE_W  = 8;
  localparam int POS_W   = 5;
  localparam int ADDR_W  = $clog2(MAX_FRAME_LEN);
  localparam int LEN_W   = $clog2(MAX_FRAME_LEN + 1);
  localparam int CFG_IDX_W = 2;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_TYPE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT    = 2'd1;

  localparam logic ACTION_BYTE = 1'b0;
  localparam logic ACTION_TICK = 1'b1;

  localparam logic KIND_ECHO  = 1'b0;
  localparam logic KIND_FRAME = 1'b1;

  typedef enum logic [2:0] {
    P_IDLE,
    P_LENGTH,
    P_TYPE,
    P_OPTION,
    P_PAYLOAD
  } parse_state_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_READ,
    B_SEND
  } back_state_t;

  // Write port of the frame store, driven by the parser.
  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [BYTE_W-1:0] data;
  } store_wr_t;

  // One job for the emitter: an echoed byte, or a frame of the given length.
  typedef struct packed {
    logic              is_frame;
    logic [BYTE_W-1:0] value;
  } job_t;

endpackage
`default_nettype wire

[design/uart_command_frame_parser_top.sv]
// Accepts one input transfer per cycle while the job queue is not full and no frame
// is pending; a tick or a header byte gives no result. An echo passes through the
// job queue into the output register. A completed frame is queued as a job; each byte
// is read from the store and loaded into the output register; input is held off until
// the last frame byte is in the output register. Synchronous active-high reset clears the
// parser, queue and emitter at once; the frame store needs no clearing pass.
`default_nettype none
module uart_command_frame_parser_top
  import ucfp_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 s_tvalid,
  output logic                      s_tready,
  input  wire logic [7:0]           s_tdata,   // [7:0] rx_data
  input  wire logic                 s_tuser,   // [0] action
  output logic                      m_tvalid,
  input  wire logic                 m_tready,
  output logic [15:0]               m_tdata,   // [7:0] data, [12:8] position, [15:13] zero
  output logic                      m_tuser,   // [0] kind
  output logic                      m_tlast,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [BYTE_W-1:0]    cfg_data
);

  logic              q_full, q_empty, q_push, q_pop, frame_done;
  job_t              q_job, q_head;
  store_wr_t         wr;
  logic [BYTE_W-1:0] out_data;
  logic [POS_W-1:0]  out_pos;

  assign cfg_ready = 1'b1;
  assign m_tdata   = {3'b000, out_pos, out_data};

  ucfp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_action  (s_tuser),
    .in_byte    (s_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_job      (q_job),
    .frame_done (frame_done),
    .wr         (wr)
  );

  ucfp_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_job (q_job),
    .full     (q_full),
    .pop      (q_pop),
    .empty    (q_empty),
    .head     (q_head)
  );

  ucfp_back u_back (
    .clk        (clk),
    .rst        (rst),
    .wr         (wr),
    .q_empty    (q_empty),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .frame_done (frame_done),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_kind   (m_tuser),
    .out_data   (out_data),
    .out_pos    (out_pos),
    .out_last   (m_tlast)
  );

endmodule
`default_nettype wire

[design/ucfp_front.sv]
`default_nettype none
module ucfp_front
  import ucfp_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic                 in_action,
  input  wire logic [BYTE_W-1:0]    in_byte,
  input  wire logic                 cfg_valid,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [BYTE_W-1:0]    cfg_data,
  input  wire logic                 q_full,
  output logic                      q_push,
  output job_t                      q_job,
  input  wire logic                 frame_done,
  output store_wr_t                 wr
);

  parse_state_t      state, state_next, cur_state;
  logic [BYTE_W-1:0] frame_type_code;
  logic [BYTE_W-1:0] timeout_ticks;
  logic [BYTE_W-1:0] countdown;
  logic [LEN_W-1:0]  frame_len, frame_len_next;
  logic [LEN_W-1:0]  remaining, remaining_next;
  logic              frame_pending;
  logic              accept, is_byte, is_len;
  logic [LEN_W-1:0]  rx_len;
  logic [LEN_W-1:0]  payload_len;
  logic [LEN_W-1:0]  pay_pos;
  logic              enq_frame;

  // A frame job owns the store until the emitter has read it all out.
  assign in_ready = !q_full && !frame_pending;
  assign accept   = in_valid && in_ready;
  assign is_byte  = accept && (in_action == ACTION_BYTE);
  assign is_len   = (in_byte >= BYTE_W'(MIN_FRAME_LEN)) && (in_byte <= BYTE_W'(MAX_FRAME_LEN));
  assign rx_len   = LEN_W'(in_byte);
  assign payload_len = frame_len - LEN_W'(HEADER_LEN);
  assign pay_pos     = frame_len - remaining;

  // An expired countdown sends the byte through the idle branch.
  assign cur_state = (countdown == '0) ? P_IDLE : state;

  always_comb begin
    state_next = state;
    if (is_byte) begin
      case (cur_state)
        P_IDLE:    state_next = is_len ? P_LENGTH : P_IDLE;
        P_LENGTH: begin
          if (in_byte == frame_type_code) begin
            state_next = P_TYPE;
          end else if (!is_len) begin
            state_next = P_IDLE;
          end else begin
            state_next = P_LENGTH;
          end
        end
        P_TYPE:    state_next = P_OPTION;
        P_OPTION:  state_next = (payload_len != '0) ? P_PAYLOAD : P_IDLE;
        P_PAYLOAD: state_next = (remaining == LEN_W'(1)) ? P_IDLE : P_PAYLOAD;
        default:   state_next = P_IDLE;
      endcase
    end
  end

  always_comb begin
    wr             = '0;
    q_push         = 1'b0;
    q_job          = '0;
    enq_frame      = 1'b0;
    frame_len_next = frame_len;
    remaining_next = remaining;
    if (is_byte) begin
      case (cur_state)
        P_IDLE: begin
          if (is_len) begin
            wr             = '{en: 1'b1, addr: ADDR_W'(0), data: in_byte};
            frame_len_next = rx_len;
          end else begin
            q_push = 1'b1;
            q_job  = '{is_frame: 1'b0, value: in_byte};
          end
        end
        P_LENGTH: begin
          if (in_byte == frame_type_code) begin
            wr = '{en: 1'b1, addr: ADDR_W'(1), data: in_byte};
          end
        end
        P_TYPE: wr = '{en: 1'b1, addr: ADDR_W'(2), data: in_byte};
        P_OPTION: begin
          wr             = '{en: 1'b1, addr: ADDR_W'(3), data: in_byte};
          remaining_next = payload_len;
          enq_frame      = (payload_len == '0);
        end
        P_PAYLOAD: begin
          wr             = '{en: 1'b1, addr: ADDR_W'(pay_pos), data: in_byte};
          remaining_next = remaining - LEN_W'(1);
          enq_frame      = (remaining == LEN_W'(1));
        end
        default: ;
      endcase
      if (enq_frame) begin
        q_push = 1'b1;
        q_job  = '{is_frame: 1'b1, value: BYTE_W'(frame_len)};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= P_IDLE;
      countdown       <= '0;
      remaining       <= '0;
      frame_len       <= '0;
      frame_pending   <= 1'b0;
      frame_type_code <= '0;
      timeout_ticks   <= BYTE_W'(TIMEOUT_RESET);
    end else begin
      state     <= state_next;
      remaining <= remaining_next;
      frame_len <= frame_len_next;
      if (is_byte) begin
        countdown <= timeout_ticks;
      end else if (accept && countdown != '0) begin
        countdown <= countdown - BYTE_W'(1);
      end
      if (enq_frame) begin
        frame_pending <= 1'b1;
      end else if (frame_done) begin
        frame_pending <= 1'b0;
      end
      if (cfg_valid) begin
        case (cfg_index)
          CFG_FRAME_TYPE: frame_type_code <= cfg_data;
          CFG_TIMEOUT:    timeout_ticks   <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // The store must not change under a frame that is still being emitted.
  a_no_write_while_pending: assert property (@(posedge clk) disable iff (rst)
    frame_pending |-> !wr.en)
    else $error("frame store written while a frame is pending");

  a_payload_pos_range: assert property (@(posedge clk) disable iff (rst)
    (state == P_PAYLOAD) |-> (remaining != '0) && (remaining <= frame_len))
    else $error("payload counter out of range");

endmodule
`default_nettype wire

[design/ucfp_queue.sv]
`default_nettype none
module ucfp_queue
  import ucfp_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire job_t push_job,
  output logic      full,
  input  wire logic pop,
  output logic      empty,
  output job_t      head
);

  job_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full  = (count == QCNT_W'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      count <= count + QCNT_W'(push) - QCNT_W'(pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    full |-> !push)
    else $error("job queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    empty |-> !pop)
    else $error("job queue underflow");

endmodule
`default_nettype wire

[design/ucfp_back.sv]
`default_nettype none
module ucfp_back
  import ucfp_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire store_wr_t    wr,
  input  wire logic         q_empty,
  input  wire job_t         q_head,
  output logic              q_pop,
  output logic              frame_done,
  output logic              out_valid,
  input  wire logic         out_ready,
  output logic              out_kind,
  output logic [BYTE_W-1:0] out_data,
  output logic [POS_W-1:0]  out_pos,
  output logic              out_last
);

  back_state_t       state, state_next;
  logic [BYTE_W-1:0] store [MAX_FRAME_LEN];
  logic [BYTE_W-1:0] rd_data;
  logic [ADDR_W-1:0] idx;
  logic [LEN_W-1:0]  run_len;
  logic              slot_free;
  logic              load_echo, load_frame, start_frame, last_byte;

  assign slot_free = !out_valid || out_ready;
  assign last_byte = (LEN_W'(idx) + LEN_W'(1)) == run_len;

  always_comb begin
    state_next = state;
    case (state)
      B_IDLE: begin
        if (!q_empty && q_head.is_frame) begin
          state_next = B_READ;
        end
      end
      B_READ: state_next = B_SEND;
      B_SEND: begin
        if (slot_free) begin
          state_next = last_byte ? B_IDLE : B_READ;
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  always_comb begin
    load_echo   = 1'b0;
    load_frame  = 1'b0;
    start_frame = 1'b0;
    q_pop       = 1'b0;
    frame_done  = 1'b0;
    case (state)
      B_IDLE: begin
        if (!q_empty) begin
          if (q_head.is_frame) begin
            start_frame = 1'b1;
            q_pop       = 1'b1;
          end else if (slot_free) begin
            load_echo = 1'b1;
            q_pop     = 1'b1;
          end
        end
      end
      B_SEND: begin
        load_frame = slot_free;
        frame_done = slot_free && last_byte;
      end
      default: ;
    endcase
  end

  // Frame store: one write port from the parser, one registered read port.
  always_ff @(posedge clk) begin
    if (wr.en) begin
      store[wr.addr] <= wr.data;
    end
    rd_data <= store[idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      out_valid <= 1'b0;
      idx       <= '0;
      run_len   <= '0;
    end else begin
      state <= state_next;
      if (start_frame) begin
        idx     <= '0;
        run_len <= LEN_W'(q_head.value);
      end else if (load_frame && !last_byte) begin
        idx <= idx + ADDR_W'(1);
      end
      if (load_echo || load_frame) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_echo) begin
      out_kind <= KIND_ECHO;
      out_data <= q_head.value;
      out_pos  <= '0;
      out_last <= 1'b1;
    end else if (load_frame) begin
      out_kind <= KIND_FRAME;
      out_data <= rd_data;
      out_pos  <= POS_W'(idx);
      out_last <= last_byte;
    end
  end

  a_idx_in_run: assert property (@(posedge clk) disable iff (rst)
    (state == B_SEND) |-> (LEN_W'(idx) < run_len))
    else $error("frame read index beyond frame length");

endmodule
`default_nettype wire
